>>> rtl/core/sac_pkg.sv
`timescale 1ns / 1ps
package sac_pkg;

  localparam int unsigned ReqW    = 11;
  localparam int unsigned HdrW    = 5;
  localparam int unsigned TotW    = 13;
  localparam int unsigned OffOutW = 17;
  localparam int unsigned MapW    = 8;
  localparam int unsigned BlockSh = 10;

  localparam logic [HdrW-1:0] HEADER_RESET     = 5'd8;
  localparam logic [TotW-1:0] CLASS0_LIMIT     = 13'd128;
  localparam logic [TotW-1:0] CLASS1_LIMIT     = 13'd256;
  localparam logic [TotW-1:0] CLASS2_LIMIT     = 13'd512;
  localparam logic [TotW-1:0] CLASS3_LIMIT     = 13'd1024;
  localparam logic [MapW-1:0] FIRST_SLOT_MAP   = 8'h01;

  // register index of header_bytes
  localparam logic REG_HEADER_BYTES = 1'b0;

  typedef enum logic [1:0] {
    CLS_128  = 2'd0,
    CLS_256  = 2'd1,
    CLS_512  = 2'd2,
    CLS_1024 = 2'd3
  } size_class_e;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_EXHAUSTED = 2'd2
  } alloc_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_UPD,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [ReqW-1:0] key_length;
    logic [ReqW-1:0] value_length;
  } req_t;

  typedef struct packed {
    logic [OffOutW-1:0] byte_offset;
    logic [ReqW-1:0]    slot_bytes;
    alloc_status_e      status;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic latch_hit;
    logic rd_map;
    logic upd_slot;
    logic claim;
    logic set_too_large;
    logic set_exhausted;
    logic load_out;
  } sac_cmd_t;

  typedef struct packed {
    logic too_large;
    logic grp_hit;
    logic last_grp;
    logic pool_full;
    logic out_free;
  } sac_sts_t;

  function automatic logic [ReqW-1:0] class_bytes(input size_class_e cls);
    logic [ReqW-1:0] r;
    case (cls)
      CLS_128:  r = 11'd128;
      CLS_256:  r = 11'd256;
      CLS_512:  r = 11'd512;
      CLS_1024: r = 11'd1024;
      default:  r = 11'd0;
    endcase
    return r;
  endfunction

  // slots that exist in a block of the class
  function automatic logic [MapW-1:0] class_mask(input size_class_e cls);
    logic [MapW-1:0] r;
    case (cls)
      CLS_128:  r = 8'hFF;
      CLS_256:  r = 8'h0F;
      CLS_512:  r = 8'h03;
      CLS_1024: r = 8'h01;
      default:  r = 8'h00;
    endcase
    return r;
  endfunction

  // byte offset of a slot inside its 1 KB block
  function automatic logic [BlockSh-1:0] slot_offset(input size_class_e cls,
                                                     input logic [2:0] slot);
    logic [BlockSh-1:0] r;
    case (cls)
      CLS_128:  r = {slot, 7'b0};
      CLS_256:  r = {slot[1:0], 8'b0};
      CLS_512:  r = {slot[0], 9'b0};
      CLS_1024: r = '0;
      default:  r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/slab_size_class_allocator_unit.sv
`timescale 1ns / 1ps
// Slab allocator with 128/256/512/1024-byte size classes over NUM_BLOCKS blocks
// of 1 KB. Each request (key and value length plus the header_bytes register)
// returns one beat: the byte offset of the granted slot, the slot size and a
// status (granted, too large, pool exhausted). One request is in flight at a
// time. The search walks the per-block class/full flags 32 blocks per cycle.
// A too-large request goes from the first scan state straight to the result;
// a hit in any group then reads and rewrites the slot bitmap in the map
// memory (S_READ, then S_UPD), and a new block claim finishes right after the
// last group. The result sits in an output register, and the next request
// is taken once it has been handed over to that register. No clearing pass is
// needed after reset: a block's bitmap is written when the block is claimed.
module slab_size_class_allocator_unit #(
  parameter int unsigned NUM_BLOCKS = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sac_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sac_pkg::rsp_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic [sac_pkg::HdrW-1:0] header_q;
  logic                     reg_idx;
  sac_pkg::sac_cmd_t        cmd;
  sac_pkg::sac_sts_t        sts;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= sac_pkg::HEADER_RESET;
    end else if (psel && penable && pwrite && (reg_idx == sac_pkg::REG_HEADER_BYTES)) begin
      header_q <= pwdata[sac_pkg::HdrW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == sac_pkg::REG_HEADER_BYTES) begin
      prdata = 32'(header_q);
    end
  end

  sac_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sac_dp #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (in_data_i),
    .header_i   (header_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/core/sac_ram.sv
`timescale 1ns / 1ps
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/sac_ctrl.sv
`timescale 1ns / 1ps
module sac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sac_pkg::sac_sts_t sts_i,
  output sac_pkg::sac_cmd_t cmd_o
);

  sac_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sac_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sac_pkg::S_IDLE: begin
        if (in_valid_i) state_d = sac_pkg::S_SCAN;
      end
      sac_pkg::S_SCAN: begin
        if (sts_i.too_large) begin
          state_d = sac_pkg::S_DONE;
        end else if (sts_i.grp_hit) begin
          state_d = sac_pkg::S_READ;
        end else if (sts_i.last_grp) begin
          state_d = sac_pkg::S_DONE;
        end
      end
      sac_pkg::S_READ: state_d = sac_pkg::S_UPD;
      sac_pkg::S_UPD:  state_d = sac_pkg::S_DONE;
      sac_pkg::S_DONE: begin
        if (sts_i.out_free) state_d = sac_pkg::S_IDLE;
      end
      default: state_d = sac_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      sac_pkg::S_IDLE: begin
        in_stall_o     = 1'b0;
        cmd_o.load_req = in_valid_i;
      end
      sac_pkg::S_SCAN: begin
        if (sts_i.too_large) begin
          cmd_o.set_too_large = 1'b1;
        end else if (sts_i.grp_hit) begin
          cmd_o.latch_hit = 1'b1;
        end else if (sts_i.last_grp) begin
          cmd_o.claim         = !sts_i.pool_full;
          cmd_o.set_exhausted = sts_i.pool_full;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      sac_pkg::S_READ: cmd_o.rd_map = 1'b1;
      sac_pkg::S_UPD:  cmd_o.upd_slot = 1'b1;
      sac_pkg::S_DONE: cmd_o.load_out = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/sac_dp.sv
`timescale 1ns / 1ps
module sac_dp #(
  parameter int unsigned NUM_BLOCKS = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sac_pkg::req_t                req_i,
  input  logic [sac_pkg::HdrW-1:0]     header_i,
  input  sac_pkg::sac_cmd_t            cmd_i,
  output sac_pkg::sac_sts_t            sts_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sac_pkg::rsp_t                out_data_o
);

  localparam int unsigned BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned GRP_W   = (NUM_BLOCKS < 32) ? NUM_BLOCKS : 32;
  localparam int unsigned NUM_GRP = (NUM_BLOCKS + GRP_W - 1) / GRP_W;
  localparam int unsigned GI_W    = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int unsigned GP_W    = (GRP_W > 1) ? $clog2(GRP_W) : 1;
  localparam int unsigned PAD     = NUM_GRP * GRP_W;
  localparam int unsigned OFF_W   = (BLK_W + 10 > 17) ? BLK_W + 10 : 17;
  localparam int unsigned MW      = sac_pkg::MapW;

  // per-block state
  logic [NUM_BLOCKS-1:0]  taken_q;
  logic [NUM_BLOCKS-1:0]  full_q;
  sac_pkg::size_class_e   cls_q [NUM_BLOCKS];
  logic [CNT_W-1:0]       count_q;

  // request state
  sac_pkg::size_class_e   req_cls_q;
  logic                   too_large_q;
  logic [GI_W-1:0]        grp_q;
  logic [BLK_W-1:0]       blk_q;
  sac_pkg::rsp_t          res_q;
  sac_pkg::rsp_t          out_q;
  logic                   out_valid_q;

  logic [sac_pkg::TotW-1:0] total;
  sac_pkg::size_class_e     new_cls;
  logic [PAD-1:0]           cand;
  logic [GRP_W-1:0]         grp_vec;
  logic [GP_W-1:0]          pos;
  logic [GI_W+GP_W-1:0]     hit_wide;
  logic [BLK_W-1:0]         hit_blk;
  logic [BLK_W-1:0]         claim_blk;
  logic [MW-1:0]            map_rd;
  logic [MW-1:0]            mask;
  logic [MW-1:0]            free_slots;
  logic [2:0]               slot;
  logic [MW-1:0]            new_map;
  logic                     full_after;
  logic [OFF_W-1:0]         hit_off;
  logic [OFF_W-1:0]         claim_off;
  logic                     ram_we;
  logic [BLK_W-1:0]         ram_waddr;
  logic [MW-1:0]            ram_wdata;
  logic [MW-1:0]            ram_rdata;

  // size class of the incoming request
  always_comb begin
    total = sac_pkg::TotW'(req_i.key_length) + sac_pkg::TotW'(req_i.value_length)
          + sac_pkg::TotW'(header_i);
    if (total <= sac_pkg::CLASS0_LIMIT) begin
      new_cls = sac_pkg::CLS_128;
    end else if (total <= sac_pkg::CLASS1_LIMIT) begin
      new_cls = sac_pkg::CLS_256;
    end else if (total <= sac_pkg::CLASS2_LIMIT) begin
      new_cls = sac_pkg::CLS_512;
    end else begin
      new_cls = sac_pkg::CLS_1024;
    end
  end

  // blocks of the requested class that still have a free slot
  for (genvar b = 0; b < PAD; b++) begin : g_cand
    if (b < NUM_BLOCKS) begin : g_real
      assign cand[b] = taken_q[b] && (cls_q[b] == req_cls_q) && !full_q[b];
    end else begin : g_pad
      assign cand[b] = 1'b0;
    end
  end

  assign grp_vec = cand[grp_q * GRP_W +: GRP_W];

  always_comb begin
    pos = '0;
    for (int i = GRP_W - 1; i >= 0; i--) begin
      if (grp_vec[i]) pos = GP_W'(i);
    end
  end

  assign hit_wide  = {grp_q, pos};
  assign hit_blk   = hit_wide[BLK_W-1:0];
  assign claim_blk = count_q[BLK_W-1:0];

  // lowest free slot in the block read back from the map memory
  assign map_rd     = ram_rdata;
  assign mask       = sac_pkg::class_mask(req_cls_q);
  assign free_slots = ~map_rd & mask;

  always_comb begin
    slot = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (free_slots[i]) slot = 3'(i);
    end
  end

  assign new_map    = map_rd | (MW'(1) << slot);
  assign full_after = &(new_map | ~mask);
  assign hit_off    = OFF_W'({blk_q, 10'b0})
                    | OFF_W'(sac_pkg::slot_offset(req_cls_q, slot));
  assign claim_off  = OFF_W'({claim_blk, 10'b0});

  assign ram_we    = cmd_i.upd_slot || cmd_i.claim;
  assign ram_waddr = cmd_i.claim ? claim_blk : blk_q;
  assign ram_wdata = cmd_i.claim ? sac_pkg::FIRST_SLOT_MAP : new_map;

  sac_ram #(
    .WIDTH(MW),
    .DEPTH(NUM_BLOCKS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_map),
    .raddr_i(blk_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q     <= '0;
      full_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
        cls_q[b] <= sac_pkg::CLS_128;
      end
    end else begin
      if (cmd_i.claim) begin
        taken_q[claim_blk] <= 1'b1;
        cls_q[claim_blk]   <= req_cls_q;
        full_q[claim_blk]  <= (req_cls_q == sac_pkg::CLS_1024);
        count_q            <= count_q + CNT_W'(1);
      end
      if (cmd_i.upd_slot) begin
        full_q[blk_q] <= full_after;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_cls_q   <= new_cls;
      too_large_q <= (total > sac_pkg::CLASS3_LIMIT);
      grp_q       <= '0;
    end else if (cmd_i.scan_step) begin
      grp_q <= grp_q + GI_W'(1);
    end
    if (cmd_i.latch_hit) begin
      blk_q <= hit_blk;
    end
    if (cmd_i.upd_slot) begin
      res_q.byte_offset <= hit_off[sac_pkg::OffOutW-1:0];
      res_q.slot_bytes  <= sac_pkg::class_bytes(req_cls_q);
      res_q.status      <= sac_pkg::ST_GRANTED;
    end else if (cmd_i.claim) begin
      res_q.byte_offset <= claim_off[sac_pkg::OffOutW-1:0];
      res_q.slot_bytes  <= sac_pkg::class_bytes(req_cls_q);
      res_q.status      <= sac_pkg::ST_GRANTED;
    end else if (cmd_i.set_too_large) begin
      res_q.byte_offset <= '0;
      res_q.slot_bytes  <= '0;
      res_q.status      <= sac_pkg::ST_TOO_LARGE;
    end else if (cmd_i.set_exhausted) begin
      res_q.byte_offset <= '0;
      res_q.slot_bytes  <= '0;
      res_q.status      <= sac_pkg::ST_EXHAUSTED;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign sts_o.too_large = too_large_q;
  assign sts_o.grp_hit   = |grp_vec;
  assign sts_o.last_grp  = (grp_q == GI_W'(NUM_GRP - 1));
  assign sts_o.pool_full = (count_q == CNT_W'(NUM_BLOCKS));
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int unsigned NUM_BLOCKS   = 128;
  localparam int unsigned NUM_DIR      = 23;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 20;

  localparam logic [2:0] HDR_ADDR    = {sac_pkg::REG_HEADER_BYTES, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = 3'd4;

  // random request kinds
  localparam int unsigned PICK_NOISE = 4;

  typedef struct packed {
    sac_pkg::req_t req;
    logic          chk;
    sac_pkg::rsp_t rsp;
  } dir_row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  sac_pkg::req_t in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  sac_pkg::rsp_t out_data_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  slab_size_class_allocator_unit #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // allocator shadow state
  logic [sac_pkg::HdrW-1:0] hdr_q;
  logic                     blk_taken [NUM_BLOCKS];
  sac_pkg::size_class_e     blk_cls   [NUM_BLOCKS];
  logic [sac_pkg::MapW-1:0] blk_map   [NUM_BLOCKS];

  sac_pkg::rsp_t pending_rsp_q [$];
  int unsigned   err_cnt;
  int            tx_quiet;
  int            rx_quiet;
  bit            hold_req;
  bit            hold_done;
  dir_row_t      dir_tab [NUM_DIR];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_cnt++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  // random wait, with runs of back-to-back beats now and then
  function automatic int unsigned draw_wait(inout int quiet);
    int unsigned n;
    if (quiet > 0) begin
      quiet--;
      n = 0;
    end else if ($urandom_range(0, 29) == 0) begin
      quiet = $urandom_range(10, 40);
      n = 0;
    end else begin
      n = $urandom_range(0, 12);
    end
    return n;
  endfunction

  function automatic sac_pkg::rsp_t alloc_predict(input sac_pkg::req_t r);
    logic [sac_pkg::TotW-1:0] total;
    sac_pkg::size_class_e     cls;
    int unsigned              nslots;
    int unsigned              bytes;
    bit                       found;
    sac_pkg::rsp_t            p;
    total = sac_pkg::TotW'(r.key_length) + sac_pkg::TotW'(r.value_length)
          + sac_pkg::TotW'(hdr_q);
    p.byte_offset = '0;
    p.slot_bytes  = '0;
    p.status      = sac_pkg::ST_EXHAUSTED;
    found = 1'b0;
    if (total > sac_pkg::CLASS3_LIMIT) begin
      p.status = sac_pkg::ST_TOO_LARGE;
    end else begin
      if (total <= sac_pkg::CLASS0_LIMIT) cls = sac_pkg::CLS_128;
      else if (total <= sac_pkg::CLASS1_LIMIT) cls = sac_pkg::CLS_256;
      else if (total <= sac_pkg::CLASS2_LIMIT) cls = sac_pkg::CLS_512;
      else cls = sac_pkg::CLS_1024;
      bytes  = 128 << int'(cls);
      nslots = 8 >> int'(cls);
      // lowest free slot among blocks already owned by the class
      for (int b = 0; b < NUM_BLOCKS && !found; b++) begin
        if (blk_taken[b] && blk_cls[b] == cls) begin
          for (int s = 0; s < nslots && !found; s++) begin
            if (!blk_map[b][s]) begin
              blk_map[b][s] = 1'b1;
              found = 1'b1;
              p.byte_offset = sac_pkg::OffOutW'(b * 1024 + s * bytes);
              p.slot_bytes  = sac_pkg::ReqW'(bytes);
              p.status      = sac_pkg::ST_GRANTED;
            end
          end
        end
      end
      // otherwise claim the lowest unclaimed block
      for (int b = 0; b < NUM_BLOCKS && !found; b++) begin
        if (!blk_taken[b]) begin
          blk_taken[b] = 1'b1;
          blk_cls[b]   = cls;
          blk_map[b]   = sac_pkg::FIRST_SLOT_MAP;
          found = 1'b1;
          p.byte_offset = sac_pkg::OffOutW'(b * 1024);
          p.slot_bytes  = sac_pkg::ReqW'(bytes);
          p.status      = sac_pkg::ST_GRANTED;
        end
      end
    end
    return p;
  endfunction

  // pick: 0..3 aims at a size class, PICK_NOISE gives arbitrary lengths
  function automatic sac_pkg::req_t make_req(input int unsigned pick);
    sac_pkg::req_t r;
    int unsigned   lo;
    int unsigned   hi;
    int unsigned   t;
    int unsigned   rest;
    if (pick >= PICK_NOISE) begin
      r.key_length   = sac_pkg::ReqW'($urandom_range(0, 2047));
      r.value_length = sac_pkg::ReqW'($urandom_range(0, 2047));
    end else begin
      hi = 128 << pick;
      lo = (pick == 0) ? 0 : hi / 2 + 1;
      if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 1) ? hi : lo;
      else t = $urandom_range(lo, hi);
      rest = (t > hdr_q) ? t - hdr_q : 0;
      r.key_length   = sac_pkg::ReqW'($urandom_range(0, rest));
      r.value_length = sac_pkg::ReqW'(rest - r.key_length);
    end
    return r;
  endfunction

  function automatic int unsigned pick_kind(input int phase);
    int unsigned w0, w1, w2, w3;
    int unsigned x;
    case (phase)
      1: begin w0 = 70; w1 = 85; w2 = 90; w3 = 93; end
      2: begin w0 = 30; w1 = 50; w2 = 65; w3 = 80; end
      default: begin w0 = 25; w1 = 40; w2 = 55; w3 = 80; end
    endcase
    x = $urandom_range(0, 99);
    if (x < w0) return 0;
    else if (x < w1) return 1;
    else if (x < w2) return 2;
    else if (x < w3) return 3;
    else return PICK_NOISE;
  endfunction

  task automatic send_req(input sac_pkg::req_t r, input logic chk,
                          input sac_pkg::rsp_t typed);
    int unsigned   gap;
    sac_pkg::rsp_t p;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (in_stall_o);
    p = alloc_predict(r);
    pending_rsp_q.push_back(chk ? typed : p);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == HDR_ADDR) hdr_q = data[sac_pkg::HdrW-1:0];
  endtask

  task automatic apb_check_hdr();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= HDR_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(32 - sac_pkg::HdrW){1'b0}}, hdr_q}) begin
      report_mismatch("header_bytes readback", prdata, hdr_q);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stop offering the last beat again, then let the block drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int phase, input int unsigned n_items,
                           input logic [31:0] hdr_word);
    sac_pkg::rsp_t none;
    none = '0;
    wait_idle();
    apb_write(HDR_ADDR, hdr_word);
    apb_check_hdr();
    if (phase == 2) begin
      // receiver parks for a long while, sender keeps pushing
      hold_req = 1'b1;
      tx_quiet = 30;
    end
    for (int unsigned i = 0; i < n_items; i++) begin
      send_req(make_req(pick_kind(phase)), 1'b0, none);
    end
  endtask

  // result side
  initial begin
    int unsigned   n;
    sac_pkg::rsp_t want;
    out_stall_i <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = draw_wait(rx_quiet);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_rsp_q.size() == 0) begin
        report_mismatch("beat with nothing pending, byte_offset",
                        out_data_o.byte_offset, 0);
      end else begin
        want = pending_rsp_q.pop_front();
        if (out_data_o.byte_offset !== want.byte_offset)
          report_mismatch("byte_offset", out_data_o.byte_offset, want.byte_offset);
        if (out_data_o.slot_bytes !== want.slot_bytes)
          report_mismatch("slot_bytes", out_data_o.slot_bytes, want.slot_bytes);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
      end
    end
  end

  // request side and configuration
  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    err_cnt   = 0;
    tx_quiet  = 0;
    rx_quiet  = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    hdr_q     = sac_pkg::HEADER_RESET;
    for (int b = 0; b < NUM_BLOCKS; b++) begin
      blk_taken[b] = 1'b0;
      blk_cls[b]   = sac_pkg::CLS_128;
      blk_map[b]   = '0;
    end

    // header is 8 here; rows with chk clear go through the predictor
    dir_tab = '{
      '{'{11'd0,    11'd0},    1'b1, '{17'd0,    11'd128,  sac_pkg::ST_GRANTED}},
      '{'{11'd2047, 11'd2047}, 1'b1, '{17'd0,    11'd0,    sac_pkg::ST_TOO_LARGE}},
      '{'{11'd1016, 11'd0},    1'b1, '{17'd1024, 11'd1024, sac_pkg::ST_GRANTED}},
      '{'{11'd0,    11'd1017}, 1'b1, '{17'd0,    11'd0,    sac_pkg::ST_TOO_LARGE}},
      '{'{11'd1024, 11'd0},    1'b1, '{17'd0,    11'd0,    sac_pkg::ST_TOO_LARGE}},
      '{'{11'd0,    11'd1024}, 1'b1, '{17'd0,    11'd0,    sac_pkg::ST_TOO_LARGE}},
      '{'{11'd1024, 11'd1024}, 1'b1, '{17'd0,    11'd0,    sac_pkg::ST_TOO_LARGE}},
      '{'{11'd120,  11'd0},    1'b1, '{17'd128,  11'd128,  sac_pkg::ST_GRANTED}},
      '{'{11'd121,  11'd0},    1'b1, '{17'd2048, 11'd256,  sac_pkg::ST_GRANTED}},
      '{'{11'd0,    11'd248},  1'b0, '0},
      '{'{11'd249,  11'd0},    1'b0, '0},
      '{'{11'd252,  11'd252},  1'b0, '0},
      '{'{11'd253,  11'd252},  1'b0, '0},
      '{'{11'd1,    11'd0},    1'b0, '0},
      '{'{11'd2,    11'd0},    1'b0, '0},
      '{'{11'd4,    11'd0},    1'b0, '0},
      '{'{11'd8,    11'd0},    1'b0, '0},
      '{'{11'd16,   11'd0},    1'b0, '0},
      '{'{11'd32,   11'd0},    1'b0, '0},
      '{'{11'd64,   11'd0},    1'b0, '0},
      '{'{11'd0,    11'd512},  1'b0, '0},
      '{'{11'd341,  11'd682},  1'b1, '{17'd0,    11'd0,    sac_pkg::ST_TOO_LARGE}},
      '{'{11'd682,  11'd341},  1'b1, '{17'd0,    11'd0,    sac_pkg::ST_TOO_LARGE}}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apb_check_hdr();
    for (int unsigned i = 0; i < NUM_DIR; i++) begin
      send_req(dir_tab[i].req, dir_tab[i].chk, dir_tab[i].rsp);
    end

    // writes to an unmapped index must leave the header alone
    wait_idle();
    apb_write(UNUSED_ADDR, 32'h0000_001F);
    apb_check_hdr();

    run_phase(1, 600, 32'h0000_0000);
    run_phase(2, 500, 32'hFFFF_FFF0);
    run_phase(3, 600, 32'hFFFF_FFFF);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/sac_pkg.sv
rtl/core/sac_ram.sv
rtl/core/sac_ctrl.sv
rtl/core/sac_dp.sv
rtl/core/slab_size_class_allocator_unit.sv
tb/tb.sv
